// File: rtl/emp_pkg.sv
// Package: sizes, codes and controller/datapath link types for the exclusion mask pair test.
`timescale 1ns / 1ps

package emp_pkg;

  localparam int MAX_ATOMS       = 4096;
  localparam int PRIMARY_DEPTH   = 1024;
  localparam int SECONDARY_DEPTH = 1024;

  localparam int ATOM_W  = 12;
  localparam int WORD_W  = 32;
  localparam int ATOM_AW = $clog2(MAX_ATOMS);
  localparam int PRIM_AW = $clog2(PRIMARY_DEPTH);
  localparam int SEC_AW  = $clog2(SECONDARY_DEPTH);
  localparam int PAIR_W  = 2 * WORD_W;

  localparam int NEAR_SPAN = 32;
  localparam int HALF_SPAN = 16;
  localparam int RUN_LEN_W = 9;

  typedef enum logic [1:0] {
    OP_QUERY        = 2'd0,
    OP_WR_INDEX     = 2'd1,
    OP_WR_PRIMARY   = 2'd2,
    OP_WR_SECONDARY = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    HOW_SAME    = 3'd0,
    HOW_PRIMARY = 3'd1,
    HOW_HALF    = 3'd2,
    HOW_RUN     = 3'd3,
    HOW_NONE    = 3'd4
  } how_e;

  typedef enum logic [1:0] {
    RES_SAME,
    RES_EVAL,
    RES_WALK,
    RES_PEND
  } res_sel_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ_PRIM,
    S_EVAL,
    S_WALK,
    S_HOLD
  } state_e;

  typedef struct packed {
    logic     accept;
    logic     rd_prim;
    logic     start_walk;
    logic     step_walk;
    logic     out_load;
    logic     pend_load;
    res_sel_e res_sel;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic same_atom;
    logic out_free;
    logic eval_run;
    logic walk_done;
  } stat_t;

endpackage

// File: rtl/emp_if.sv
// Interfaces: request and response channels of the exclusion mask pair test.
`timescale 1ns / 1ps

interface emp_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [11:0] first_atom;
  logic [11:0] second_atom;
  logic [11:0] table_address;
  logic [31:0] word_x;
  logic [31:0] word_y;

  modport source (
    output valid, operation, first_atom, second_atom, table_address, word_x, word_y,
    input  ready
  );
  modport sink (
    input  valid, operation, first_atom, second_atom, table_address, word_x, word_y,
    output ready
  );
endinterface

interface emp_rsp_if;
  logic       valid;
  logic       ready;
  logic       excluded;
  logic [2:0] decided_by;

  modport source (
    output valid, excluded, decided_by,
    input  ready
  );
  modport sink (
    input  valid, excluded, decided_by,
    output ready
  );
endinterface

// File: rtl/emp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module emp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/emp_ctrl.sv
// Controller: sequences table reads, the secondary walk and result hand-off.
`timescale 1ns / 1ps

module emp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  emp_pkg::stat_t stat_i,
  output emp_pkg::cmd_t  cmd_o
);
  import emp_pkg::*;

  state_e state_q, state_d;
  logic   decide;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    decide     = 1'b0;
    cmd_o      = '0;
    cmd_o.res_sel = RES_SAME;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (stat_i.is_query) begin
            if (stat_i.same_atom) begin
              decide = 1'b1;
            end else begin
              state_d = S_READ_PRIM;
            end
          end
        end
      end
      S_READ_PRIM: begin
        cmd_o.rd_prim = 1'b1;
        state_d       = S_EVAL;
      end
      S_EVAL: begin
        if (stat_i.eval_run) begin
          cmd_o.start_walk = 1'b1;
          state_d          = S_WALK;
        end else begin
          cmd_o.res_sel = RES_EVAL;
          decide        = 1'b1;
        end
      end
      S_WALK: begin
        if (stat_i.walk_done) begin
          cmd_o.res_sel = RES_WALK;
          decide        = 1'b1;
        end else begin
          cmd_o.step_walk = 1'b1;
        end
      end
      S_HOLD: begin
        cmd_o.res_sel = RES_PEND;
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A result goes straight to the output register when it is free,
    // otherwise it parks in the pending register.
    if (decide) begin
      if (stat_i.out_free) begin
        cmd_o.out_load = 1'b1;
        state_d        = S_IDLE;
      end else begin
        cmd_o.pend_load = 1'b1;
        state_d         = S_HOLD;
      end
    end
  end

  a_query_blocks_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.accept && stat_i.is_query && !stat_i.same_atom) |=> !in_ready_o)
    else $error("input taken while a query is in flight");

  a_hold_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pend_load |=> (state_q == S_HOLD && !in_ready_o))
    else $error("pending result not held");

endmodule

// File: rtl/emp_dp.sv
// Datapath: the three tables, pair ordering, mask decode, walk pointer and output register.
`timescale 1ns / 1ps

module emp_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  emp_pkg::cmd_t               cmd_i,
  output emp_pkg::stat_t              stat_o,
  input  logic [1:0]                  operation_i,
  input  logic [emp_pkg::ATOM_W-1:0]  first_atom_i,
  input  logic [emp_pkg::ATOM_W-1:0]  second_atom_i,
  input  logic [emp_pkg::ATOM_W-1:0]  table_address_i,
  input  logic [emp_pkg::WORD_W-1:0]  word_x_i,
  input  logic [emp_pkg::WORD_W-1:0]  word_y_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic                        excluded_o,
  output logic [2:0]                  decided_by_o
);
  import emp_pkg::*;

  logic [ATOM_W-1:0]    lo_d, hi_d, lo_q, hi_q;
  logic [SEC_AW-1:0]    ptr_q, ptr_d, sec_raddr;
  logic [RUN_LEN_W-1:0] left_q, left_d;
  logic                 pend_excl_q;
  how_e                 pend_how_q;
  logic                 out_valid_q, out_excl_q;
  how_e                 out_how_q;

  logic [PRIM_AW-1:0]   slot_rdata;
  logic [PAIR_W-1:0]    prim_rdata, sec_rdata;
  logic [WORD_W-1:0]    near, ext, sec_ref, sec_mask;

  logic                 wr_index, wr_prim, wr_sec;
  logic [ATOM_W-1:0]    pair_gap, gap_m1;
  logic [RUN_LEN_W-1:0] run_len;
  logic [16:0]          half_ref, dh, dh_m1;
  logic [15:0]          half;
  logic [32:0]          dw, dw_m1;
  logic                 half_hit, walk_hit;
  logic                 eval_excl, walk_excl, res_excl;
  how_e                 eval_how, res_how;

  // Ordering of the pair
  always_comb begin
    if (second_atom_i < first_atom_i) begin
      lo_d = second_atom_i;
      hi_d = first_atom_i;
    end else begin
      lo_d = first_atom_i;
      hi_d = second_atom_i;
    end
  end

  assign wr_index = cmd_i.accept && (operation_i == OP_WR_INDEX);
  assign wr_prim  = cmd_i.accept && (operation_i == OP_WR_PRIMARY);
  assign wr_sec   = cmd_i.accept && (operation_i == OP_WR_SECONDARY);

  emp_ram #(.WIDTH(PRIM_AW), .DEPTH(MAX_ATOMS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (wr_index),
    .waddr_i (table_address_i[ATOM_AW-1:0]),
    .wdata_i (word_x_i[PRIM_AW-1:0]),
    .re_i    (cmd_i.accept),
    .raddr_i (lo_d[ATOM_AW-1:0]),
    .rdata_o (slot_rdata)
  );

  emp_ram #(.WIDTH(PAIR_W), .DEPTH(PRIMARY_DEPTH)) u_prim_ram (
    .clk_i   (clk_i),
    .we_i    (wr_prim),
    .waddr_i (table_address_i[PRIM_AW-1:0]),
    .wdata_i ({word_y_i, word_x_i}),
    .re_i    (cmd_i.rd_prim),
    .raddr_i (slot_rdata),
    .rdata_o (prim_rdata)
  );

  assign near = prim_rdata[WORD_W-1:0];
  assign ext  = prim_rdata[PAIR_W-1:WORD_W];

  // Run start wraps at the secondary depth
  assign sec_raddr = cmd_i.start_walk ? ext[SEC_AW-1:0] : ptr_q + SEC_AW'(1);

  emp_ram #(.WIDTH(PAIR_W), .DEPTH(SECONDARY_DEPTH)) u_sec_ram (
    .clk_i   (clk_i),
    .we_i    (wr_sec),
    .waddr_i (table_address_i[SEC_AW-1:0]),
    .wdata_i ({word_y_i, word_x_i}),
    .re_i    (cmd_i.start_walk || cmd_i.step_walk),
    .raddr_i (sec_raddr),
    .rdata_o (sec_rdata)
  );

  assign sec_ref  = sec_rdata[WORD_W-1:0];
  assign sec_mask = sec_rdata[PAIR_W-1:WORD_W];

  // Primary decode: near mask, no extension, empty run or half mask
  assign pair_gap = hi_q - lo_q;
  assign gap_m1   = pair_gap - ATOM_W'(1);
  assign run_len  = ext[30:22];
  assign half     = ext[30:15];
  assign half_ref = {5'd0, lo_q} + {2'd0, ext[14:0]};
  assign dh       = {5'd0, hi_q} - half_ref;
  assign dh_m1    = dh - 17'd1;
  assign half_hit = !dh[16] && (dh != 17'd0) && (dh <= 17'(HALF_SPAN));

  always_comb begin
    if (pair_gap <= ATOM_W'(NEAR_SPAN)) begin
      eval_excl = near[gap_m1[4:0]];
      eval_how  = HOW_PRIMARY;
    end else if (ext == '0) begin
      eval_excl = 1'b0;
      eval_how  = HOW_NONE;
    end else if (ext[31]) begin
      eval_excl = 1'b0;
      eval_how  = HOW_RUN;
    end else begin
      eval_how = HOW_HALF;
      if (dh == 17'd0) begin
        eval_excl = 1'b1;
      end else if (half_hit) begin
        eval_excl = half[dh_m1[3:0]];
      end else begin
        eval_excl = 1'b0;
      end
    end
  end

  // Secondary entry: reference at or below the higher atom of the pair, within the span
  assign dw        = {21'd0, hi_q} - {1'b0, sec_ref};
  assign dw_m1     = dw - 33'd1;
  assign walk_hit  = !dw[32] && (dw <= 33'(NEAR_SPAN));
  assign walk_excl = walk_hit && ((dw == 33'd0) || sec_mask[dw_m1[4:0]]);

  always_comb begin
    case (cmd_i.res_sel)
      RES_SAME: begin
        res_excl = 1'b0;
        res_how  = HOW_SAME;
      end
      RES_EVAL: begin
        res_excl = eval_excl;
        res_how  = eval_how;
      end
      RES_WALK: begin
        res_excl = walk_excl;
        res_how  = HOW_RUN;
      end
      RES_PEND: begin
        res_excl = pend_excl_q;
        res_how  = pend_how_q;
      end
      default: begin
        res_excl = 1'b0;
        res_how  = HOW_SAME;
      end
    endcase
  end

  always_comb begin
    ptr_d  = ptr_q;
    left_d = left_q;
    if (cmd_i.start_walk) begin
      ptr_d  = ext[SEC_AW-1:0];
      left_d = run_len;
    end else if (cmd_i.step_walk) begin
      ptr_d  = ptr_q + SEC_AW'(1);
      left_d = left_q - RUN_LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
    ptr_q  <= ptr_d;
    left_q <= left_d;
    if (cmd_i.pend_load) begin
      pend_excl_q <= res_excl;
      pend_how_q  <= res_how;
    end
    if (cmd_i.out_load) begin
      out_excl_q <= res_excl;
      out_how_q  <= res_how;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.is_query  = (operation_i == OP_QUERY);
  assign stat_o.same_atom = (first_atom_i == second_atom_i);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;
  assign stat_o.eval_run  = (pair_gap > ATOM_W'(NEAR_SPAN)) && ext[31] && (run_len != '0);
  assign stat_o.walk_done = walk_hit || (left_q == RUN_LEN_W'(1));

  assign out_valid_o  = out_valid_q;
  assign excluded_o   = out_excl_q;
  assign decided_by_o = out_how_q;

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten before transfer");

  a_step_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step_walk |-> (left_q > RUN_LEN_W'(1)))
    else $error("secondary walk stepped past the run");

  a_one_sink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.out_load && cmd_i.pend_load))
    else $error("result sent to both output and pending register");

endmodule

// File: rtl/exclusion_mask_pair_test.sv
// Top level: exclusion mask pair test, controller plus datapath.
//
// Request channel req_i carries write items and pair queries; response channel
// rsp_o carries one result per query and nothing for writes. Both transfer when
// valid and ready are high at a rising clock edge.
// Writes land in their table at the transfer edge.
// A query of two equal atoms reads no table and answers from the output register.
// Other queries read the index table, then the primary table, and are then decided;
// a query that walks a secondary run examines its secondary entries in turn (up
// to 511), through the single read port of the secondary table.
// Writes are taken one per cycle while the controller is idle; no new item is
// taken while a query is in flight or a result waits in the pending register.
// A finished result sits in the output register; new items are taken while it
// waits. If the receiver stalls and a second result is ready, it parks in a
// pending register and the request side stops until the first one is taken.
// Reset clears the controller and the output valid flag; table contents are
// undefined until written and are not cleared.
`timescale 1ns / 1ps

module exclusion_mask_pair_test (
  input  logic      clk_i,
  input  logic      rst_ni,
  emp_req_if.sink   req_i,
  emp_rsp_if.source rsp_o
);
  import emp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  emp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  emp_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .operation_i     (req_i.operation),
    .first_atom_i    (req_i.first_atom),
    .second_atom_i   (req_i.second_atom),
    .table_address_i (req_i.table_address),
    .word_x_i        (req_i.word_x),
    .word_y_i        (req_i.word_y),
    .out_ready_i     (rsp_o.ready),
    .out_valid_o     (rsp_o.valid),
    .excluded_o      (rsp_o.excluded),
    .decided_by_o    (rsp_o.decided_by)
  );

endmodule

// File: test/tb.sv
// Testbench for the exclusion mask pair test: directed rows, then random traffic checked by a predictor.
`timescale 1ns / 1ps

module tb;
  import emp_pkg::*;

  localparam int RANDOM_ITEMS = 2000;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 600;
  localparam int HALF_OFF_W   = 15;

  typedef struct {
    op_e         op;
    logic [11:0] a;
    logic [11:0] b;
    logic [11:0] addr;
    logic [31:0] wx;
    logic [31:0] wy;
    bit          typed;
    bit          t_excl;
    how_e        t_how;
  } emp_item_t;

  typedef struct {
    bit   excl;
    how_e how;
  } verdict_t;

  logic clk_i;
  logic rst_ni;

  emp_req_if req_ch ();
  emp_rsp_if rsp_ch ();

  exclusion_mask_pair_test uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  // shadow tables
  logic [PRIM_AW-1:0] slot_of_atom [MAX_ATOMS];
  logic [31:0]        near_mask    [PRIMARY_DEPTH];
  logic [31:0]        ext_word     [PRIMARY_DEPTH];
  logic [31:0]        sec_ref_atom [SECONDARY_DEPTH];
  logic [31:0]        sec_bits     [SECONDARY_DEPTH];
  bit                 atom_written [MAX_ATOMS];
  bit                 prim_written [PRIMARY_DEPTH];
  bit                 sec_written  [SECONDARY_DEPTH];
  int                 written_atoms[$];
  int                 written_slots[$];

  verdict_t  expected_verdicts[$];
  emp_item_t upcoming[$];
  int        failures     = 0;
  int        quiet_cycles = 0;
  int        burst_left   = 1;
  int        gap_left     = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void judge_pair(input logic [11:0] a_in, input logic [11:0] b_in,
                                     output bit excl, output how_e how);
    logic [11:0]        lo;
    logic [11:0]        hi;
    logic [PRIM_AW-1:0] slot;
    logic [31:0]        near_w;
    logic [31:0]        ext_w;
    int unsigned        pair_gap;
    int unsigned        run_len;
    int                 sidx;
    longint             d;
    excl = 1'b0;
    how  = HOW_SAME;
    if (a_in == b_in) return;
    lo       = (a_in < b_in) ? a_in : b_in;
    hi       = (a_in < b_in) ? b_in : a_in;
    slot     = slot_of_atom[lo];
    near_w   = near_mask[slot];
    ext_w    = ext_word[slot];
    pair_gap = hi - lo;
    if (pair_gap <= NEAR_SPAN) begin
      excl = near_w[pair_gap - 1];
      how  = HOW_PRIMARY;
      return;
    end
    if (ext_w == 32'd0) begin
      how = HOW_NONE;
      return;
    end
    if (ext_w[31]) begin
      how     = HOW_RUN;
      run_len = ext_w[30:22];
      for (int k = 0; k < run_len; k++) begin
        sidx = (int'(ext_w[21:0]) + k) % SECONDARY_DEPTH;
        d    = longint'(hi) - longint'(sec_ref_atom[sidx]);
        if (d == 0) begin
          excl = 1'b1;
          return;
        end
        if (d > 0 && d <= NEAR_SPAN) begin
          excl = sec_bits[sidx][int'(d) - 1];
          return;
        end
      end
      return;
    end
    how = HOW_HALF;
    d   = longint'(hi) - (longint'(lo) + longint'(ext_w[HALF_OFF_W-1:0]));
    if (d == 0) excl = 1'b1;
    else if (d > 0 && d <= HALF_SPAN) excl = ext_w[HALF_OFF_W + int'(d) - 1];
  endfunction

  // Update the shadow tables for one accepted transfer; queries queue their verdict.
  function automatic void absorb_transfer(input emp_item_t it);
    int       idx;
    verdict_t v;
    case (it.op)
      OP_WR_INDEX: begin
        idx = it.addr % MAX_ATOMS;
        slot_of_atom[idx] = PRIM_AW'(it.wx % PRIMARY_DEPTH);
        if (!atom_written[idx]) written_atoms.insert(written_atoms.size(), idx);
        atom_written[idx] = 1'b1;
      end
      OP_WR_PRIMARY: begin
        idx = it.addr % PRIMARY_DEPTH;
        near_mask[idx] = it.wx;
        ext_word[idx]  = it.wy;
        if (!prim_written[idx]) written_slots.insert(written_slots.size(), idx);
        prim_written[idx] = 1'b1;
      end
      OP_WR_SECONDARY: begin
        idx = it.addr % SECONDARY_DEPTH;
        sec_ref_atom[idx] = it.wx;
        sec_bits[idx]     = it.wy;
        sec_written[idx]  = 1'b1;
      end
      default: begin
        if (it.typed) begin
          v.excl = it.t_excl;
          v.how  = it.t_how;
        end else begin
          judge_pair(it.a, it.b, v.excl, v.how);
        end
        expected_verdicts.insert(expected_verdicts.size(), v);
      end
    endcase
  endfunction

  function automatic emp_item_t noise_item(input op_e op);
    emp_item_t it;
    it.op     = op;
    it.a      = 12'($urandom());
    it.b      = 12'($urandom());
    it.addr   = 12'($urandom());
    it.wx     = $urandom();
    it.wy     = $urandom();
    it.typed  = 1'b0;
    it.t_excl = 1'b0;
    it.t_how  = HOW_SAME;
    return it;
  endfunction

  function automatic emp_item_t dir_write(input op_e op, input logic [11:0] addr,
                                          input logic [31:0] wx, input logic [31:0] wy);
    emp_item_t it;
    it      = noise_item(op);
    it.a    = 12'd0;
    it.b    = 12'd0;
    it.addr = addr;
    it.wx   = wx;
    it.wy   = wy;
    return it;
  endfunction

  function automatic emp_item_t dir_query(input logic [11:0] a, input logic [11:0] b,
                                          input bit typed, input bit excl, input how_e how);
    emp_item_t it;
    it        = noise_item(OP_QUERY);
    it.a      = a;
    it.b      = b;
    it.typed  = typed;
    it.t_excl = excl;
    it.t_how  = how;
    return it;
  endfunction

  function automatic emp_item_t fresh_secondary(input int slot);
    emp_item_t it;
    int        r;
    it      = noise_item(OP_WR_SECONDARY);
    it.addr = 12'(slot + SECONDARY_DEPTH * $urandom_range(0, 3));
    r       = $urandom_range(0, 99);
    if (r < 70) it.wx = $urandom_range(0, MAX_ATOMS - 1);
    else if (r < 80)
      it.wx = written_atoms[$urandom_range(0, written_atoms.size() - 1)] + $urandom_range(0, 60);
    else if (r < 95) it.wx = $urandom();
    else it.wx = $urandom_range(0, 1) ? 32'hffff_ffff : 32'd0;
    r = $urandom_range(0, 9);
    if (r == 0) it.wy = 32'd0;
    else if (r == 1) it.wy = 32'hffff_ffff;
    return it;
  endfunction

  // Queries other than same-atom ones name a lower atom whose index and primary entries exist.
  function automatic emp_item_t random_query();
    emp_item_t          it;
    logic [11:0]        lo;
    logic [PRIM_AW-1:0] slot;
    logic [31:0]        ext_w;
    int unsigned        run_len;
    int                 sidx;
    longint             cand;
    it = noise_item(OP_QUERY);
    if ($urandom_range(0, 9) == 0) begin
      it.b = it.a;
      return it;
    end
    lo    = written_atoms[$urandom_range(0, written_atoms.size() - 1)];
    slot  = slot_of_atom[lo];
    ext_w = ext_word[slot];
    case ($urandom_range(0, 9))
      0, 1, 2: cand = longint'(lo) + $urandom_range(1, NEAR_SPAN);
      3, 4, 5, 6, 7: begin
        run_len = ext_w[30:22];
        if (ext_w[31] && run_len > 0) begin
          sidx = (int'(ext_w[21:0]) + $urandom_range(0, run_len - 1)) % SECONDARY_DEPTH;
          cand = longint'(sec_ref_atom[sidx]) + longint'($urandom_range(0, 34)) - 1;
        end else if (ext_w != 32'd0 && !ext_w[31]) begin
          cand = longint'(lo) + longint'(ext_w[HALF_OFF_W-1:0])
                 + longint'($urandom_range(0, 18)) - 1;
        end else begin
          cand = longint'(lo) + $urandom_range(NEAR_SPAN + 1, 200);
        end
      end
      default: cand = -1;
    endcase
    if (cand <= longint'(lo) || cand > MAX_ATOMS - 1)
      cand = (lo == 12'hfff) ? 4095 : $urandom_range(int'(lo) + 1, MAX_ATOMS - 1);
    if ($urandom_range(0, 1)) begin
      it.a = lo;
      it.b = 12'(cand);
    end else begin
      it.a = 12'(cand);
      it.b = lo;
    end
    return it;
  endfunction

  function automatic void plan_next();
    emp_item_t it;
    int        pick;
    int        r;
    int        run_len;
    int        start;
    int        off;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      upcoming.insert(upcoming.size(), random_query());
    end else if (pick < 73) begin
      it    = noise_item(OP_WR_INDEX);
      it.wx = {it.wx[31:PRIM_AW],
               PRIM_AW'(written_slots[$urandom_range(0, written_slots.size() - 1)])};
      upcoming.insert(upcoming.size(), it);
    end else if (pick < 87) begin
      it = noise_item(OP_WR_PRIMARY);
      r  = $urandom_range(0, 9);
      if (r == 0) it.wx = 32'd0;
      else if (r == 1) it.wx = 32'hffff_ffff;
      r = $urandom_range(0, 9);
      if (r < 2) begin
        it.wy = 32'd0;
      end else if (r < 6) begin
        off   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 32767) : $urandom_range(20, 300);
        it.wy = {1'b0, 16'($urandom()), 15'(off)};
      end else begin
        r       = $urandom_range(0, 99);
        run_len = (r < 85) ? $urandom_range(0, 12)
                : (r < 95) ? $urandom_range(13, 64) : $urandom_range(65, 511);
        start   = $urandom_range(0, 32'h003f_ffff);
        it.wy   = {1'b1, 9'(run_len), 22'(start)};
        // every entry the run may visit gets written first
        for (int k = 0; k < run_len; k++)
          if (!sec_written[(start + k) % SECONDARY_DEPTH])
            upcoming.insert(upcoming.size(),
                            fresh_secondary((start + k) % SECONDARY_DEPTH));
      end
      upcoming.insert(upcoming.size(), it);
    end else begin
      upcoming.insert(upcoming.size(),
                      fresh_secondary($urandom_range(0, SECONDARY_DEPTH - 1)));
    end
  endfunction

  task automatic send_item(input emp_item_t it);
    if (gap_left > 0) begin
      req_ch.valid <= 1'b0;
      while (gap_left > 0) begin
        @(posedge clk_i);
        gap_left--;
      end
    end
    req_ch.valid         <= 1'b1;
    req_ch.operation     <= it.op;
    req_ch.first_atom    <= it.a;
    req_ch.second_atom   <= it.b;
    req_ch.table_address <= it.addr;
    req_ch.word_x        <= it.wx;
    req_ch.word_y        <= it.wy;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
    absorb_transfer(it);
    if (burst_left > 1) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 12);
      gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end
  endtask

  task automatic pause_until_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (expected_verdicts.size() != 0);
  endtask

  initial begin : stimulus
    emp_item_t rows[$];
    int        sent;
    rst_ni               <= 1'b0;
    req_ch.valid         <= 1'b0;
    req_ch.operation     <= OP_QUERY;
    req_ch.first_atom    <= '0;
    req_ch.second_atom   <= '0;
    req_ch.table_address <= '0;
    req_ch.word_x        <= '0;
    req_ch.word_y        <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // same atom needs no table
    rows.insert(rows.size(), dir_query(12'd4095, 12'd4095, 1, 0, HOW_SAME));
    rows.insert(rows.size(), dir_write(OP_WR_INDEX, 12'd0, 32'd5, 32'hffff_ffff));
    rows.insert(rows.size(), dir_write(OP_WR_PRIMARY, 12'd5, 32'h8000_0001, 32'd0));
    rows.insert(rows.size(), dir_query(12'd0, 12'd1, 1, 1, HOW_PRIMARY));
    rows.insert(rows.size(), dir_query(12'd32, 12'd0, 1, 1, HOW_PRIMARY));
    rows.insert(rows.size(), dir_query(12'd0, 12'd2, 1, 0, HOW_PRIMARY));
    rows.insert(rows.size(), dir_query(12'd0, 12'd4095, 1, 0, HOW_NONE));
    // half mask: slot value and primary address both wrap to slot 7
    rows.insert(rows.size(), dir_write(OP_WR_INDEX, 12'd100, 32'hffff_fc07, 32'd0));
    rows.insert(rows.size(), dir_write(OP_WR_PRIMARY, 12'h407, 32'd0, 32'h7fff_8028));
    rows.insert(rows.size(), dir_query(12'd140, 12'd100, 0, 0, HOW_SAME));
    rows.insert(rows.size(), dir_query(12'd100, 12'd156, 0, 0, HOW_SAME));
    rows.insert(rows.size(), dir_query(12'd100, 12'd157, 0, 0, HOW_SAME));
    rows.insert(rows.size(), dir_query(12'd100, 12'd139, 0, 0, HOW_SAME));
    rows.insert(rows.size(), dir_query(12'd100, 12'd105, 0, 0, HOW_SAME));
    // secondary run of two starting at the top slot and wrapping to slot 0
    rows.insert(rows.size(), dir_write(OP_WR_INDEX, 12'd200, 32'd9, 32'd0));
    rows.insert(rows.size(), dir_write(OP_WR_SECONDARY, 12'h3ff, 32'd300, 32'h0000_0001));
    rows.insert(rows.size(), dir_write(OP_WR_SECONDARY, 12'h400, 32'd310, 32'h8000_0000));
    rows.insert(rows.size(), dir_write(OP_WR_PRIMARY, 12'd9, 32'hffff_ffff, 32'h80bf_ffff));
    rows.insert(rows.size(), dir_query(12'd200, 12'd300, 0, 0, HOW_SAME));
    rows.insert(rows.size(), dir_query(12'd200, 12'd301, 0, 0, HOW_SAME));
    rows.insert(rows.size(), dir_query(12'd200, 12'd340, 0, 0, HOW_SAME));
    rows.insert(rows.size(), dir_query(12'd342, 12'd200, 0, 0, HOW_SAME));
    // empty run
    rows.insert(rows.size(), dir_write(OP_WR_INDEX, 12'd400, 32'h0000_040a, 32'd0));
    rows.insert(rows.size(), dir_write(OP_WR_PRIMARY, 12'd10, 32'd0, 32'h8000_0005));
    rows.insert(rows.size(), dir_query(12'd400, 12'd500, 0, 0, HOW_SAME));
    foreach (rows[i]) send_item(rows[i]);
    pause_until_drained();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (upcoming.size() == 0) plan_next();
      send_item(upcoming.pop_front());
      sent++;
      if (sent == RANDOM_ITEMS / 2) pause_until_drained();
    end
    req_ch.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (failures == 0 && expected_verdicts.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // receiver: quiet, light and heavy stall stretches
  initial begin : rsp_stall
    int stall_left;
    int mode;
    int mode_left;
    stall_left = 0;
    mode       = 0;
    mode_left  = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      if (stall_left > 0) stall_left--;
      else if (mode == 1 && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 4);
      else if (mode == 2 && $urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 12);
      rsp_ch.ready <= (stall_left == 0);
    end
  end

  always @(posedge clk_i) begin : check_results
    verdict_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_verdicts.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected transfer: excluded=%0d decided_by=%0d",
                   rsp_ch.excluded, rsp_ch.decided_by);
      end else begin
        want = expected_verdicts.pop_front();
        if (rsp_ch.excluded !== want.excl || rsp_ch.decided_by !== want.how) begin
          failures++;
          if (failures <= 10)
            $display("mismatch: expected excluded=%0d decided_by=%s, got excluded=%0d decided_by=%0d",
                     want.excl, want.how.name(), rsp_ch.excluded, rsp_ch.decided_by);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule
